FILE: rtl/totp_pkg.sv
// ----------------------------------------------------------------------------
// TOTP validator package
// Shared types, constants and command encoding for the TOTP HMAC-SHA1 block.
// ----------------------------------------------------------------------------
package totp_pkg;

  // Field widths.
  localparam int unsigned TimeW   = 63;
  localparam int unsigned CodeW   = 20;
  localparam int unsigned KeyW    = 80;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgW    = 64;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_KEY_HI = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LO = 8'd1;

  // Arithmetic constants.
  localparam logic [5:0]  STEP_SECONDS = 6'd30;
  localparam logic [20:0] CODE_MOD     = 21'd1000000;
  localparam logic [7:0]  IPAD_BYTE    = 8'h36;
  localparam logic [7:0]  OPAD_BYTE    = 8'h5c;

  // Reciprocals: ceil(2^26 / 30) for 21-bit dividends, and
  // ceil(2^39 / 15625) for the truncated value shifted right by six.
  localparam logic [21:0] DIV_RECIP = 22'd2236963;
  localparam logic [25:0] MOD_RECIP = 26'd35184373;

  // Message lengths in bits for the second block of each keyed hash.
  localparam logic [63:0] INNER_BITS = 64'd576;
  localparam logic [63:0] OUTER_BITS = 64'd672;

  // SHA-1 initial hash value.
  localparam logic [31:0] SHA_IV [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // SHA-1 round constants, one per group of twenty rounds.
  localparam logic [31:0] SHA_K [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  // Block codes for the four compressions.
  typedef enum logic [1:0] {
    BLK_KEY_IN  = 2'd0,
    BLK_MSG_IN  = 2'd1,
    BLK_KEY_OUT = 2'd2,
    BLK_MSG_OUT = 2'd3
  } blk_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_TRUNC,
    ST_MOD,
    ST_DONE
  } state_e;

  // Input transaction.
  typedef struct packed {
    logic [TimeW-1:0] unix_time;
    logic [CodeW-1:0] candidate_code;
  } req_t;

  // Result transaction.
  typedef struct packed {
    logic             code_valid;
    logic [CodeW-1:0] computed_code;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_in;
    logic       div_step;
    logic       load_blk;
    blk_e       blk_sel;
    logic       round;
    logic [1:0] phase;
    logic       add;
    logic       trunc;
    logic       mod_quot;
    logic       mod_step;
  } cmd_t;

  // Rotate left.
  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage

FILE: rtl/totp_dp.sv
// ----------------------------------------------------------------------------
// TOTP datapath
// Divide-by-30 unit on 16-bit digits, SHA-1 round engine with sliding
// schedule, truncation and reduction modulo one million by reciprocal.
// ----------------------------------------------------------------------------
module totp_dp import totp_pkg::*; (
  input  logic            clk_i,
  input  logic [KeyW-1:0] key_i,
  input  req_t            req_i,
  input  cmd_t            cmd_i,
  output rsp_t            rsp_o
);

  logic [63:0]      dq_q, dq_d;
  logic [4:0]       drem_q, drem_d;
  logic [CodeW-1:0] cand_q, cand_d;
  logic [31:0]      w_q [16];
  logic [31:0]      w_d [16];
  logic [31:0]      h_q [5];
  logic [31:0]      h_d [5];
  logic [31:0]      v_q [5];
  logic [31:0]      v_d [5];
  logic [159:0]     inner_q, inner_d;
  logic [30:0]      bin_q, bin_d;
  logic [11:0]      mquot_q, mquot_d;
  logic [CodeW-1:0] mrem_q, mrem_d;

  logic [20:0]  div_x;
  logic [42:0]  div_prod;
  logic [15:0]  div_q;
  logic [20:0]  div_sub;
  logic [50:0]  mod_prod;
  logic [511:0] blk;
  logic [511:0] pad_rep;
  logic [31:0]  f_val;
  logic [31:0]  t_val;
  logic [159:0] digest;
  logic [159:0] trunc_sh;

  // One 16-bit digit of the division by 30 per step, by reciprocal.
  assign div_x    = {drem_q, dq_q[63:48]};
  assign div_prod = {22'b0, div_x} * {21'b0, DIV_RECIP};
  assign div_q    = div_prod[41:26];
  assign div_sub  = div_x - ({5'b0, div_q} * {15'b0, STEP_SECONDS});

  // Quotient of the truncated value by one million, as (bin / 64) / 15625.
  assign mod_prod = {26'b0, bin_q[30:6]} * {25'b0, MOD_RECIP};

  // Current digest and its dynamic truncation window.
  assign digest   = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
  assign trunc_sh = digest << {h_q[4][3:0], 3'b000};

  // Message block selection for the four compressions.
  always_comb begin
    pad_rep = {64{IPAD_BYTE}};
    blk     = '0;
    unique case (cmd_i.blk_sel)
      BLK_KEY_IN: begin
        blk = {key_i, 432'b0} ^ {64{IPAD_BYTE}};
      end
      BLK_MSG_IN: begin
        blk = {dq_q, 32'h80000000, 352'b0, INNER_BITS};
      end
      BLK_KEY_OUT: begin
        pad_rep = {64{OPAD_BYTE}};
        blk     = {key_i, 432'b0} ^ pad_rep;
      end
      BLK_MSG_OUT: begin
        blk = {inner_q, 32'h80000000, 256'b0, OUTER_BITS};
      end
      default: blk = '0;
    endcase
  end

  // Round function for the current group of rounds.
  always_comb begin
    unique case (cmd_i.phase)
      2'd0:    f_val = (v_q[1] & v_q[2]) | (~v_q[1] & v_q[3]);
      2'd2:    f_val = (v_q[1] & v_q[2]) | (v_q[1] & v_q[3]) | (v_q[2] & v_q[3]);
      default: f_val = v_q[1] ^ v_q[2] ^ v_q[3];
    endcase
    t_val = rotl(v_q[0], 5) + f_val + v_q[4] + SHA_K[cmd_i.phase] + w_q[0];
  end

  // Next-state logic of all datapath registers.
  always_comb begin
    dq_d    = dq_q;
    drem_d  = drem_q;
    cand_d  = cand_q;
    w_d     = w_q;
    h_d     = h_q;
    v_d     = v_q;
    inner_d = inner_q;
    bin_d   = bin_q;
    mquot_d = mquot_q;
    mrem_d  = mrem_q;

    if (cmd_i.load_in) begin
      dq_d   = {1'b0, req_i.unix_time};
      drem_d = '0;
      cand_d = req_i.candidate_code;
    end

    // One quotient digit per step; the remainder stays below 30.
    if (cmd_i.div_step) begin
      drem_d = div_sub[4:0];
      dq_d   = {dq_q[47:0], div_q};
    end

    // Block load: schedule window, and chaining value from IV or prior block.
    if (cmd_i.load_blk) begin
      for (int i = 0; i < 16; i++) begin
        w_d[i] = blk[511-32*i -: 32];
      end
      if (cmd_i.blk_sel == BLK_KEY_IN || cmd_i.blk_sel == BLK_KEY_OUT) begin
        h_d = SHA_IV;
        v_d = SHA_IV;
      end else begin
        v_d = h_q;
      end
      if (cmd_i.blk_sel == BLK_KEY_OUT) begin
        inner_d = digest;
      end
    end

    // One compression round, and the schedule window slides by one word.
    if (cmd_i.round) begin
      v_d[0] = t_val;
      v_d[1] = v_q[0];
      v_d[2] = rotl(v_q[1], 30);
      v_d[3] = v_q[2];
      v_d[4] = v_q[3];
      for (int i = 0; i < 15; i++) begin
        w_d[i] = w_q[i+1];
      end
      w_d[15] = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
    end

    if (cmd_i.add) begin
      for (int i = 0; i < 5; i++) begin
        h_d[i] = h_q[i] + v_q[i];
      end
    end

    if (cmd_i.trunc) begin
      bin_d  = trunc_sh[158:128];
      mrem_d = '0;
    end

    // Reduction: quotient first, then the remainder below one million.
    if (cmd_i.mod_quot) begin
      mquot_d = mod_prod[50:39];
    end

    if (cmd_i.mod_step) begin
      mrem_d = CodeW'(bin_q - ({19'b0, mquot_q} * {10'b0, CODE_MOD}));
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q    <= dq_d;
    drem_q  <= drem_d;
    cand_q  <= cand_d;
    w_q     <= w_d;
    h_q     <= h_d;
    v_q     <= v_d;
    inner_q <= inner_d;
    bin_q   <= bin_d;
    mquot_q <= mquot_d;
    mrem_q  <= mrem_d;
  end

  // Result fields.
  assign rsp_o.computed_code = mrem_q;
  assign rsp_o.code_valid    = (cand_q == mrem_q);

endmodule

FILE: rtl/totp_ctrl.sv
// ----------------------------------------------------------------------------
// TOTP controller
// Sequences the divide, four SHA-1 compressions, truncation and reduction.
// ----------------------------------------------------------------------------
module totp_ctrl import totp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  output logic done_o,
  output cmd_t cmd_o
);

  state_e     state_q, state_d;
  logic [6:0] cnt_q, cnt_d;
  blk_e       blk_q, blk_d;

  // Next state and counters.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    blk_d   = blk_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        blk_d = BLK_KEY_IN;
        if (start_i) state_d = ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd3) begin
          cnt_d   = '0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cnt_d   = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd79) state_d = ST_ADD;
      end
      ST_ADD: begin
        cnt_d = '0;
        if (blk_q == BLK_MSG_OUT) begin
          state_d = ST_TRUNC;
        end else begin
          blk_d   = blk_e'(blk_q + 2'd1);
          state_d = ST_LOAD;
        end
      end
      ST_TRUNC: begin
        cnt_d   = '0;
        state_d = ST_MOD;
      end
      ST_MOD: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd1) state_d = ST_DONE;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o         = '0;
    cmd_o.blk_sel = blk_q;
    if (cnt_q < 7'd20)      cmd_o.phase = 2'd0;
    else if (cnt_q < 7'd40) cmd_o.phase = 2'd1;
    else if (cnt_q < 7'd60) cmd_o.phase = 2'd2;
    else                    cmd_o.phase = 2'd3;
    busy_o = (state_q != ST_IDLE);
    done_o = 1'b0;
    unique case (state_q)
      ST_IDLE:  cmd_o.load_in  = start_i;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_LOAD:  cmd_o.load_blk = 1'b1;
      ST_ROUND: cmd_o.round    = 1'b1;
      ST_ADD:   cmd_o.add      = 1'b1;
      ST_TRUNC: cmd_o.trunc    = 1'b1;
      ST_MOD: begin
        if (cnt_q == 7'd0) cmd_o.mod_quot = 1'b1;
        else               cmd_o.mod_step = 1'b1;
      end
      ST_DONE:  done_o         = 1'b1;
      default:  done_o         = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      blk_q   <= BLK_KEY_IN;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      blk_q   <= blk_d;
    end
  end

endmodule

FILE: rtl/totp_hmac_sha1_validator_unit.sv
// ----------------------------------------------------------------------------
// TOTP HMAC-SHA1 validator
// Checks a six-digit one-time code against the HMAC-SHA1 TOTP of a time.
// ----------------------------------------------------------------------------
// A transaction is accepted when start_i is high while busy_o is low. The
// result is on result_o while done_o is high for exactly one cycle, after
// division by 30, one 16-bit digit per cycle by reciprocal multiplication,
// four SHA-1 compressions on a one-round-per-cycle engine, truncation and
// reduction modulo one million. The receiver must take the result in that
// cycle. The key registers are always ready and must only be written
// while idle.
module totp_hmac_sha1_validator_unit import totp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  req_t               req_i,
  output logic               done_o,
  output rsp_t               result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  logic [63:0] key_hi_q, key_hi_d;
  logic [15:0] key_lo_q, key_lo_d;
  cmd_t        cmd;

  // Key register writes; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    key_hi_d = key_hi_q;
    key_lo_d = key_lo_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_KEY_HI) key_hi_d = cfg_data_i;
      if (cfg_index_i == CFG_KEY_LO) key_lo_d = cfg_data_i[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else begin
      key_hi_q <= key_hi_d;
      key_lo_q <= key_lo_d;
    end
  end

  // Sequencer.
  totp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // Hash and arithmetic datapath.
  totp_dp u_dp (
    .clk_i(clk_i),
    .key_i({key_hi_q, key_lo_q}),
    .req_i(req_i),
    .cmd_i(cmd),
    .rsp_o(result_o)
  );

endmodule
